// ===== sv/kstat_pkg.sv =====
// Shared types, constants and helpers for the per-key ADC sample statistics block.
`default_nettype none

package kstat_pkg;

    // Field widths fixed by the transaction format
    localparam int KEY_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int CLIP_W   = 32;
    localparam int RES_W    = 5;

    // Resolution register: reset value and the cap at which full scale stops growing
    localparam logic [RES_W-1:0]    RES_RESET = 5'd12;
    localparam logic [RES_W-1:0]    RES_CAP   = 5'd16;
    localparam logic [CLIP_W-1:0]   CLIP_MAX  = 32'hFFFF_FFFF;
    localparam logic [SAMPLE_W-1:0] FS_MAX    = 16'hFFFF;

    // One table entry: extremes and saturating clip count of a key
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
        logic [CLIP_W-1:0]   clip_cnt;
    } key_stats_t;

    // Full-scale code for a given resolution
    function automatic logic [SAMPLE_W-1:0] full_scale(input logic [RES_W-1:0] res);
        logic [SAMPLE_W:0] one_hot;
        one_hot = (SAMPLE_W + 1)'(1) << res;
        if (res >= RES_CAP)
        begin
            return FS_MAX;
        end
        return SAMPLE_W'(one_hot - (SAMPLE_W + 1)'(1));
    endfunction

endpackage

`default_nettype wire

// ===== sv/per_key_adc_sample_statistics_top.sv =====
// Per-key ADC sample statistics: table update pipeline with registered result.
//
// Usage: each input transaction carries a key_index and a sample_value on a
// valid/ready channel. Every transaction yields exactly one result transaction
// on the output valid/ready channel with the key's updated minimum, maximum and
// saturating clip count, plus accepted (key in range) and clipped flags. Keys at
// or above KEY_COUNT leave the table alone and return all-zero fields.
// The configuration port (cfg_write_en/cfg_write_data) sets the ADC resolution
// that defines the full-scale clip threshold; write it only while idle.
//
// Throughput: one transaction per cycle while out_ready stays high. The
// accepting edge loads the update stage together with the registered read of
// the statistics memory, and the result register loads from the update logic
// when the update stage advances. A one-entry write-forwarding register
// covers back-to-back transactions to the same key.
// Reset: seen flags clear at once (an unseen key reads as zero clip count),
// the resolution returns to 12, and both channels empty. When the receiver
// stalls, the result register holds, the update stage holds behind it, and
// in_ready drops only once both are full.
`default_nettype none

module per_key_adc_sample_statistics_top
    import kstat_pkg::*;
#(
    parameter int KEY_COUNT = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [RES_W-1:0]    cfg_write_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [KEY_W-1:0]    key_index,
    input  wire logic [SAMPLE_W-1:0] sample_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     accepted,
    output logic                     clipped,
    output logic [SAMPLE_W-1:0]      key_minimum,
    output logic [SAMPLE_W-1:0]      key_maximum,
    output logic [CLIP_W-1:0]        key_clip_total
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(KEY_COUNT);

    // Configuration
    logic [RES_W-1:0] res_reg;

    // Update stage
    logic                s1_valid_reg;
    logic                s1_inrange_reg;
    logic [IDX_W-1:0]    s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // Statistics memory and seen flags
    key_stats_t           stats_mem [KEY_COUNT];
    key_stats_t           rd_data_reg;
    logic [KEY_COUNT-1:0] seen_reg;

    // Write forwarding
    logic             byp_valid_reg;
    logic [IDX_W-1:0] byp_addr_reg;
    key_stats_t       byp_data_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accepted_reg;
    logic                clipped_reg;
    logic [SAMPLE_W-1:0] key_minimum_reg;
    logic [SAMPLE_W-1:0] key_maximum_reg;
    logic [CLIP_W-1:0]   key_clip_total_reg;

    logic             in_fire;
    logic             in_range;
    logic [IDX_W-1:0] in_addr;
    logic             s1_advance;
    logic             wr_en;
    key_stats_t       old_stats;
    key_stats_t       new_stats;
    logic             seen;
    logic             clip;
    logic [CLIP_W-1:0] old_clip;

    // Handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;
    assign in_range   = key_index < KEY_LIMIT;
    assign in_addr    = key_index[IDX_W-1:0];

    // Hold the resolution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
        end
        else if (cfg_write_en)
        begin
            res_reg <= cfg_write_data;
        end
    end

    // Advance the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_inrange_reg <= in_range;
            s1_addr_reg    <= in_addr;
            s1_sample_reg  <= sample_value;
        end
    end

    // Read the table at acceptance, write back from the update stage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stats_mem[s1_addr_reg] <= new_stats;
        end
        if (in_fire && in_range)
        begin
            rd_data_reg <= stats_mem[in_addr];
        end
    end

    // Mark keys seen and remember the latest write for forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            seen_reg[s1_addr_reg] <= 1'b1;
            byp_valid_reg         <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= new_stats;
        end
    end

    // Compute the updated entry
    always_comb
    begin
        old_stats = (byp_valid_reg && byp_addr_reg == s1_addr_reg) ? byp_data_reg : rd_data_reg;
        seen      = seen_reg[s1_addr_reg];
        clip      = s1_sample_reg >= full_scale(res_reg);
        old_clip  = seen ? old_stats.clip_cnt : '0;

        if (!seen)
        begin
            new_stats.min_val = s1_sample_reg;
            new_stats.max_val = s1_sample_reg;
        end
        else
        begin
            new_stats.min_val = (s1_sample_reg < old_stats.min_val) ? s1_sample_reg
                                                                    : old_stats.min_val;
            new_stats.max_val = (s1_sample_reg > old_stats.max_val) ? s1_sample_reg
                                                                    : old_stats.max_val;
        end

        if (clip && old_clip != CLIP_MAX)
        begin
            new_stats.clip_cnt = old_clip + CLIP_W'(1);
        end
        else
        begin
            new_stats.clip_cnt = old_clip;
        end

        wr_en = s1_advance && s1_inrange_reg;
    end

    // Load or drain the result register
    always_comb
    begin
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            accepted_reg       <= s1_inrange_reg;
            clipped_reg        <= s1_inrange_reg && clip;
            key_minimum_reg    <= s1_inrange_reg ? new_stats.min_val : '0;
            key_maximum_reg    <= s1_inrange_reg ? new_stats.max_val : '0;
            key_clip_total_reg <= s1_inrange_reg ? new_stats.clip_cnt : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign clipped        = clipped_reg;
    assign key_minimum    = key_minimum_reg;
    assign key_maximum    = key_maximum_reg;
    assign key_clip_total = key_clip_total_reg;

endmodule

`default_nettype wire

// ===== sv/kstat_checker.sv =====
// Port-level checker for the per-key ADC sample statistics block, with its bind.
`default_nettype none

module kstat_checker
    import kstat_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                accepted,
    input wire logic                clipped,
    input wire logic [SAMPLE_W-1:0] key_minimum,
    input wire logic [SAMPLE_W-1:0] key_maximum,
    input wire logic [CLIP_W-1:0]   key_clip_total
);

    // Rejected keys report all-zero statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> !clipped && key_minimum == '0
                                   && key_maximum == '0 && key_clip_total == '0)
    else $error("rejected key returned nonzero statistics");

    // Minimum never exceeds maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> key_minimum <= key_maximum)
    else $error("key minimum above key maximum");

    // A clipped sample leaves a nonzero clip count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> key_clip_total != '0)
    else $error("clipped sample with zero clip count");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_clip_total)
                                    && $stable(key_minimum) && $stable(key_maximum))
    else $error("stalled result changed");

endmodule

bind per_key_adc_sample_statistics_top kstat_checker u_kstat_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .clipped        (clipped),
    .key_minimum    (key_minimum),
    .key_maximum    (key_maximum),
    .key_clip_total (key_clip_total)
);

`default_nettype wire
